### design/icu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icu_pkg
// Shared opcodes, status codes and sizes for the integer calculator unit.
// ----------------------------------------------------------------------------
package icu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_RESULTS    = 30;
    localparam int OP_WIDTH       = 4;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_POW  = 4'd4,
        OP_FACT = 4'd5,
        OP_FCTL = 4'd6,
        OP_SQRT = 4'd7,
        OP_LOG  = 4'd8
    } opcode_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_DOMAIN  = 2'd2
    } status_t;

endpackage

### design/integer_calculator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_calculator_unit
// Multi-function signed integer ALU around a multiplier shared by power and factorial, one
// bit-serial divider and one bit-pair square root step, run by a sequencer.
// ----------------------------------------------------------------------------
// Usage: drive opcode, operand_a and operand_b and pulse start while busy is
// low; the word is taken at that edge. Results leave on result, status and
// last with valid high for exactly one cycle; the receiver cannot stall.
// Factorize gives one word per prime factor, smallest first, last on the
// final one; every other operation gives one word with last set.
// Add, sub, mul, divide by zero and all domain errors are answered straight
// from idle. Power steps through a multiply state and a square state per
// exponent bit. Factorial stops early once the wrapped product reaches zero.
// Divide, log and factorize run through the bit-serial divider: log divides
// repeatedly by the base, and factorize divides once per trial divisor, up
// to about sqrt(n) trials.
// busy stays high until the final word is out. Reset returns the sequencer
// to idle and drops valid.
// ----------------------------------------------------------------------------
module integer_calculator_unit #(
    parameter int DATA_WIDTH = icu_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [icu_pkg::OP_WIDTH-1:0]      opcode,
    input  logic signed [DATA_WIDTH-1:0]      operand_a,
    input  logic signed [DATA_WIDTH-1:0]      operand_b,
    output logic                              valid,
    output logic signed [DATA_WIDTH-1:0]      result,
    output logic [icu_pkg::STATUS_WIDTH-1:0]  status,
    output logic                              last
);
    import icu_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int CW     = $clog2(W + 1);
    localparam int KW     = $clog2(MAX_RESULTS);
    localparam int SQ_TOP = 2 * ((W - 1) / 2);

    typedef enum logic [3:0] {
        S_IDLE, S_POW_MUL, S_POW_SQ, S_FCTL, S_SQRT,
        S_LOG_CHK, S_FACT_TRY, S_DIV, S_DIV_END
    } state_t;

    state_t            state_reg;
    opcode_t           op_reg;
    logic [W-1:0]      a_reg, acc_reg, base_reg, e_reg, n_reg, p_reg;
    logic [W-1:0]      rem_reg, quo_reg, dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic [KW-1:0]     k_reg;
    logic              neg_reg;
    logic              valid_reg, last_reg;
    logic [W-1:0]      result_reg;
    status_t           status_reg;

    // shared multiplier
    logic [W-1:0]      mul_x, mul_y, mul_p;
    always_comb
    begin
        mul_x = acc_reg;
        mul_y = base_reg;
        unique case (state_reg)
            S_POW_SQ: mul_x = base_reg;
            S_FCTL:   mul_y = p_reg;
            default:  mul_x = acc_reg;
        endcase
    end
    assign mul_p = W'(mul_x * mul_y);

    // restoring divider step
    logic [W:0]        div_sh, div_diff;
    assign div_sh   = {rem_reg, quo_reg[W-1]};
    assign div_diff = div_sh - {1'b0, dvs_reg};

    // square root step
    logic [W:0]        sq_sum;
    assign sq_sum = {1'b0, acc_reg} + {1'b0, base_reg};

    logic [W-1:0]      mag_a, mag_b;
    opcode_t           op_in;
    assign mag_a = operand_a[W-1] ? W'(-operand_a) : operand_a;
    assign mag_b = operand_b[W-1] ? W'(-operand_b) : operand_b;
    assign op_in = opcode_t'(opcode);

    assign busy   = (state_reg != S_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;
    assign status = status_reg;
    assign last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= op_in;
                        a_reg      <= operand_a;
                        acc_reg    <= W'(1);
                        base_reg   <= operand_a;
                        e_reg      <= operand_b;
                        n_reg      <= operand_b;
                        p_reg      <= W'(2);
                        k_reg      <= '0;
                        neg_reg    <= operand_a[W-1] ^ operand_b[W-1];
                        result_reg <= '0;
                        status_reg <= ST_OK;
                        last_reg   <= 1'b1;
                        unique case (op_in)
                            OP_ADD:
                            begin
                                result_reg <= W'(operand_a + operand_b);
                                valid_reg  <= 1'b1;
                            end
                            OP_SUB:
                            begin
                                result_reg <= W'(operand_a - operand_b);
                                valid_reg  <= 1'b1;
                            end
                            OP_MUL:
                            begin
                                result_reg <= W'(operand_a * operand_b);
                                valid_reg  <= 1'b1;
                            end
                            OP_DIV:
                            begin
                                if (operand_b == '0)
                                begin
                                    status_reg <= ST_DIVZERO;
                                    valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    rem_reg   <= '0;
                                    quo_reg   <= mag_a;
                                    dvs_reg   <= mag_b;
                                    cnt_reg   <= CW'(W);
                                    state_reg <= S_DIV;
                                end
                            end
                            OP_POW:
                            begin
                                if (operand_b[W-1] || operand_b == '0)
                                begin
                                    result_reg <= W'(1);
                                    valid_reg  <= 1'b1;
                                end
                                else
                                    state_reg <= S_POW_MUL;
                            end
                            OP_FACT:
                            begin
                                if (operand_b[W-1] || operand_b < W'(2))
                                begin
                                    status_reg <= ST_DOMAIN;
                                    valid_reg  <= 1'b1;
                                end
                                else
                                    state_reg <= S_FACT_TRY;
                            end
                            OP_FCTL:
                            begin
                                if (operand_b[W-1])
                                begin
                                    status_reg <= ST_DOMAIN;
                                    valid_reg  <= 1'b1;
                                end
                                else
                                    state_reg <= S_FCTL;
                            end
                            OP_SQRT:
                            begin
                                if (operand_b[W-1])
                                begin
                                    status_reg <= ST_DOMAIN;
                                    valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    acc_reg   <= '0;
                                    base_reg  <= W'(1) << SQ_TOP;
                                    state_reg <= S_SQRT;
                                end
                            end
                            OP_LOG:
                            begin
                                if (operand_a[W-1] || operand_a < W'(2) ||
                                    operand_b[W-1] || operand_b == '0)
                                begin
                                    status_reg <= ST_DOMAIN;
                                    valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    acc_reg   <= '0;
                                    state_reg <= S_LOG_CHK;
                                end
                            end
                            default:
                            begin
                                status_reg <= ST_DOMAIN;
                                valid_reg  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_POW_MUL:
                begin
                    if (e_reg == '0)
                    begin
                        result_reg <= acc_reg;
                        valid_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (e_reg[0])
                            acc_reg <= mul_p;
                        state_reg <= S_POW_SQ;
                    end
                end
                S_POW_SQ:
                begin
                    base_reg  <= mul_p;
                    e_reg     <= e_reg >> 1;
                    state_reg <= S_POW_MUL;
                end
                S_FCTL:
                begin
                    // product goes to zero long before the counter can wrap
                    if (p_reg > n_reg || acc_reg == '0)
                    begin
                        result_reg <= acc_reg;
                        valid_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        acc_reg <= mul_p;
                        p_reg   <= p_reg + W'(1);
                    end
                end
                S_SQRT:
                begin
                    if (base_reg == '0)
                    begin
                        result_reg <= acc_reg;
                        valid_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if ({1'b0, n_reg} >= sq_sum)
                        begin
                            n_reg   <= W'({1'b0, n_reg} - sq_sum);
                            acc_reg <= (acc_reg >> 1) + base_reg;
                        end
                        else
                            acc_reg <= acc_reg >> 1;
                        base_reg <= base_reg >> 2;
                    end
                end
                S_LOG_CHK:
                begin
                    if (n_reg >= a_reg)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= n_reg;
                        dvs_reg   <= a_reg;
                        cnt_reg   <= CW'(W);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        result_reg <= acc_reg;
                        valid_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_FACT_TRY:
                begin
                    rem_reg   <= '0;
                    quo_reg   <= n_reg;
                    dvs_reg   <= p_reg;
                    cnt_reg   <= CW'(W);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!div_diff[W])
                    begin
                        rem_reg <= div_diff[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_sh[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_DIV_END;
                end
                S_DIV_END:
                begin
                    unique case (op_reg)
                        OP_DIV:
                        begin
                            result_reg <= neg_reg ? W'(-quo_reg) : quo_reg;
                            valid_reg  <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        OP_LOG:
                        begin
                            n_reg     <= quo_reg;
                            acc_reg   <= acc_reg + W'(1);
                            state_reg <= S_LOG_CHK;
                        end
                        default:
                        begin
                            // factorize: quotient below trial divisor ends it
                            if (p_reg > quo_reg ||
                                (rem_reg == '0 && k_reg == KW'(MAX_RESULTS - 1)))
                            begin
                                result_reg <= n_reg;
                                last_reg   <= 1'b1;
                                valid_reg  <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else if (rem_reg == '0)
                            begin
                                result_reg <= p_reg;
                                last_reg   <= 1'b0;
                                valid_reg  <= 1'b1;
                                k_reg      <= k_reg + KW'(1);
                                n_reg      <= quo_reg;
                                state_reg  <= S_FACT_TRY;
                            end
                            else
                            begin
                                p_reg     <= p_reg + W'(1);
                                state_reg <= S_FACT_TRY;
                            end
                        end
                    endcase
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
